@@ hdl/pixel_blend_mode_engine_unit_macros.svh @@
// Assertion macros shared by the pixel blend checker.
`ifndef PIXEL_BLEND_MODE_ENGINE_UNIT_MACROS_SVH
`define PIXEL_BLEND_MODE_ENGINE_UNIT_MACROS_SVH

// Check that cons holds after ante, delayed by the n argument.
`define PBME_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

// Check that expr holds at every clock edge out of reset.
`define PBME_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

@@ hdl/pbme_pkg.sv @@
// Shared types, constants and helpers of the pixel blend engine.
package pbme_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned ProdW     = 2 * PixW;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned WeightW   = 9;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 9;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned NumStages = 4;

  localparam logic [PixW-1:0]    ChanMax     = 8'd255;
  localparam logic [PixW-1:0]    OverlayKnee = 8'd128;
  localparam logic [WeightW-1:0] OneWeight   = 9'd256;

  // blend mode codes
  localparam logic [ModeW-1:0] ModeNormal   = 3'd0;
  localparam logic [ModeW-1:0] ModeMultiply = 3'd1;
  localparam logic [ModeW-1:0] ModeScreen   = 3'd2;
  localparam logic [ModeW-1:0] ModeOverlay  = 3'd3;
  localparam logic [ModeW-1:0] ModeDarken   = 3'd4;
  localparam logic [ModeW-1:0] ModeLighten  = 3'd5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegBlendMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMixWeight = 2'd1;

  typedef struct packed {
    logic [PixW-1:0] bg_red;
    logic [PixW-1:0] bg_green;
    logic [PixW-1:0] bg_blue;
    logic [PixW-1:0] fg_red;
    logic [PixW-1:0] fg_green;
    logic [PixW-1:0] fg_blue;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] out_red;
    logic [PixW-1:0] out_green;
    logic [PixW-1:0] out_blue;
  } pix_out_t;

  // Floor division by 255, exact for x up to 255*256-1.
  function automatic logic [PixW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] t;
    t = {1'b0, x} + {{(PixW+1){1'b0}}, x[ProdW-1:PixW]} + {{ProdW{1'b0}}, 1'b1};
    return t[ProdW-1:PixW];
  endfunction

endpackage

@@ hdl/pbme_combine_lane.sv @@
// One color channel: product stage and blend mode combine stage.
module pbme_combine_lane (
  input  logic                      clk_i,
  input  logic [pbme_pkg::PixW-1:0]  bg_i,
  input  logic [pbme_pkg::PixW-1:0]  fg_i,
  input  logic [pbme_pkg::ModeW-1:0] mode_i,
  output logic [pbme_pkg::PixW-1:0]  comb_o,
  output logic [pbme_pkg::PixW-1:0]  bg_o
);
  import pbme_pkg::*;

  logic [PixW-1:0]  bg1_q, fg1_q;
  logic [ProdW-1:0] prod_q, inv_prod_q;
  logic [ProdW-1:0] prod_d, inv_prod_d;
  logic [PixW-1:0]  comb_d, comb_q, bg2_q;

  logic [ProdW-1:0] ovl_x;
  logic [PixW-1:0]  ovl_div;
  logic             bg_low;

  assign prod_d     = ProdW'(bg_i) * ProdW'(fg_i);
  assign inv_prod_d = ProdW'(ChanMax - bg_i) * ProdW'(ChanMax - fg_i);

  // stage 1: both products feed every mode that needs one
  always_ff @(posedge clk_i) begin
    bg1_q      <= bg_i;
    fg1_q      <= fg_i;
    prod_q     <= prod_d;
    inv_prod_q <= inv_prod_d;
  end

  assign bg_low  = (bg1_q < OverlayKnee);
  // the product on the branch in use is below 2^15, so doubling stays in 16 bits
  assign ovl_x   = bg_low ? {prod_q[ProdW-2:0], 1'b0} : {inv_prod_q[ProdW-2:0], 1'b0};
  assign ovl_div = div255(ovl_x);

  always_comb begin
    case (mode_i)
      ModeMultiply: comb_d = prod_q[ProdW-1:PixW];
      ModeScreen:   comb_d = ChanMax - inv_prod_q[ProdW-1:PixW];
      ModeOverlay:  comb_d = bg_low ? ovl_div : (ChanMax - ovl_div);
      ModeDarken:   comb_d = (fg1_q < bg1_q) ? fg1_q : bg1_q;
      ModeLighten:  comb_d = (fg1_q > bg1_q) ? fg1_q : bg1_q;
      default:      comb_d = fg1_q;
    endcase
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    comb_q <= comb_d;
    bg2_q  <= bg1_q;
  end

  assign comb_o = comb_q;
  assign bg_o   = bg2_q;

endmodule

@@ hdl/pbme_mix_lane.sv @@
// One color channel: alpha weighting products and final sum.
module pbme_mix_lane (
  input  logic                        clk_i,
  input  logic [pbme_pkg::PixW-1:0]    comb_i,
  input  logic [pbme_pkg::PixW-1:0]    bg_i,
  input  logic [pbme_pkg::WeightW-1:0] weight_i,
  output logic [pbme_pkg::PixW-1:0]    pix_o
);
  import pbme_pkg::*;

  logic [WeightW-1:0] inv_weight;
  logic [ProdW-1:0]   fg_part_d, fg_part_q, bg_part_d, bg_part_q;
  logic [ProdW:0]     sum;
  logic [PixW-1:0]    pix_q;

  // weight is at most one, so each part and their sum fit in 16 bits
  assign inv_weight = OneWeight - weight_i;
  assign fg_part_d  = ProdW'(weight_i) * ProdW'(comb_i);
  assign bg_part_d  = ProdW'(inv_weight) * ProdW'(bg_i);

  // stage 3
  always_ff @(posedge clk_i) begin
    fg_part_q <= fg_part_d;
    bg_part_q <= bg_part_d;
  end

  assign sum = {1'b0, fg_part_q} + {1'b0, bg_part_q};

  // stage 4: truncate to the channel
  always_ff @(posedge clk_i) begin
    pix_q <= sum[ProdW-1:PixW];
  end

  assign pix_o = pix_q;

endmodule

@@ hdl/pixel_blend_mode_engine_unit.sv @@
// Top level of the pixel blend engine: config registers, lanes, valid pipeline.
//
//  channel   handshake                   payload
//  request   start_i (busy_o stays low)  req_i    (bg and fg RGB)
//  result    done_o strobe, one cycle    res_o    (blended RGB)
//  config    cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// Four register stages per pixel: products, mode combine, weight products,
// final sum. A valid bit shifts alongside each pixel and raises done_o with its
// result, one request per clock; no back-pressure exists, so busy_o is always
// low and the pipeline never holds.
// Reset clears the valid bits and sets mode normal with weight one.
module pixel_blend_mode_engine_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  pbme_pkg::pix_in_t             req_i,
  output logic                          done_o,
  output pbme_pkg::pix_out_t            res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pbme_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pbme_pkg::CfgDataW-1:0] cfg_data_i
);
  import pbme_pkg::*;

  logic [ModeW-1:0]     mode_q;
  logic [WeightW-1:0]   weight_q, weight_sat;
  logic [NumStages-1:0] vld_q;
  logic                 accept;

  logic [PixW-1:0] bg_in   [NumChan];
  logic [PixW-1:0] fg_in   [NumChan];
  logic [PixW-1:0] comb    [NumChan];
  logic [PixW-1:0] bg_dly  [NumChan];
  logic [PixW-1:0] pix_out [NumChan];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeNormal;
      weight_q <= OneWeight;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegBlendMode: mode_q   <= cfg_data_i[ModeW-1:0];
        RegMixWeight: weight_q <= cfg_data_i[WeightW-1:0];
        default:      ;
      endcase
    end
  end

  // clamp weights above one
  assign weight_sat = (weight_q > OneWeight) ? OneWeight : weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NumStages-2:0], accept};
    end
  end

  assign bg_in[0] = req_i.bg_red;
  assign bg_in[1] = req_i.bg_green;
  assign bg_in[2] = req_i.bg_blue;
  assign fg_in[0] = req_i.fg_red;
  assign fg_in[1] = req_i.fg_green;
  assign fg_in[2] = req_i.fg_blue;

  for (genvar ch = 0; ch < NumChan; ch++) begin : g_lane
    pbme_combine_lane u_combine (
      .clk_i  (clk_i),
      .bg_i   (bg_in[ch]),
      .fg_i   (fg_in[ch]),
      .mode_i (mode_q),
      .comb_o (comb[ch]),
      .bg_o   (bg_dly[ch])
    );

    pbme_mix_lane u_mix (
      .clk_i    (clk_i),
      .comb_i   (comb[ch]),
      .bg_i     (bg_dly[ch]),
      .weight_i (weight_sat),
      .pix_o    (pix_out[ch])
    );
  end

  assign done_o          = vld_q[NumStages-1];
  assign res_o.out_red   = pix_out[0];
  assign res_o.out_green = pix_out[1];
  assign res_o.out_blue  = pix_out[2];

endmodule

@@ hdl/pbme_checker.sv @@
// Port-level checker for the pixel blend engine and its bind.
`include "pixel_blend_mode_engine_unit_macros.svh"

module pbme_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic cfg_ready_o
);
  import pbme_pkg::*;

  logic req_taken;

  assign req_taken = start_i && !busy_o && rst_ni;

  `PBME_ASSERT_DELAY(a_result_follows, start_i && !busy_o, NumStages, done_o, "missing result")
  `PBME_ASSERT_ALWAYS(a_no_extra_result, done_o == $past(req_taken, NumStages), "result without request")
  `PBME_ASSERT_ALWAYS(a_always_open, !busy_o && cfg_ready_o, "engine refused a request")

endmodule

bind pixel_blend_mode_engine_unit pbme_checker u_pbme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .cfg_ready_o (cfg_ready_o)
);
